FILE: hw/rtl/bpd_pkg.sv
// Shared types and constants of the byte-pair decompressor.
`default_nettype none
package bpd_pkg;

   localparam int CODE_COUNT = 256;
   localparam logic [7:0] LITERAL_RUN_BASE = 8'd127;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TRUNC    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic       left_we;
      logic       right_we;
      logic       clear;
      logic [7:0] addr;
      logic [7:0] data;
   } tbl_wr_type;

endpackage
`default_nettype wire

FILE: hw/rtl/bpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/bpd_parser.sv
// Stream parser: header skip, pair table load, data length and data byte dispatch.
`default_nettype none
module bpd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                stream_end,
   output bpd_pkg::tbl_wr_type      tbl_wr,
   output logic                     start
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_COUNT  = 3'd1;
   localparam logic [2:0] PH_LEFT   = 3'd2;
   localparam logic [2:0] PH_RIGHT  = 3'd3;
   localparam logic [2:0] PH_LEN_HI = 3'd4;
   localparam logic [2:0] PH_LEN_LO = 3'd5;
   localparam logic [2:0] PH_DATA   = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hdr_ff, hdr_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  ent_ff, ent_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  len_hi_ff, len_hi_in;

   logic [9:0]  pos_sum;
   logic [8:0]  fin_pos;
   logic [7:0]  ent_dec;
   logic [15:0] rem_dec;
   logic [15:0] new_len;
   logic        is_skip;

   assign is_skip = data_byte > bpd_pkg::LITERAL_RUN_BASE;
   assign pos_sum = {1'b0, pos_ff}
                    + (is_skip ? ({2'b00, data_byte} - {2'b00, bpd_pkg::LITERAL_RUN_BASE})
                               : 10'd0);
   assign fin_pos = pos_ff + 9'd1;
   assign ent_dec = (ent_ff != 8'd0) ? ent_ff - 8'd1 : 8'd0;
   assign rem_dec = (rem_ff != 16'd0) ? rem_ff - 16'd1 : 16'd0;
   assign new_len = {len_hi_ff, data_byte};

   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      pos_in    = pos_ff;
      ent_in    = ent_ff;
      rem_in    = rem_ff;
      len_hi_in = len_hi_ff;
      tbl_wr    = '0;
      start     = 1'b0;
      tbl_wr.addr = pos_ff[7:0];
      tbl_wr.data = data_byte;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_ff == 2'd3) begin
                  hdr_in       = 2'd0;
                  pos_in       = 9'd0;
                  ent_in       = 8'd0;
                  phase_in     = PH_COUNT;
                  tbl_wr.clear = 1'b1;
               end else begin
                  hdr_in = hdr_ff + 2'd1;
               end
            end
            PH_COUNT: begin
               ent_in = is_skip ? 8'd1 : data_byte + 8'd1;
               if (pos_sum >= 10'(bpd_pkg::CODE_COUNT)) begin
                  pos_in   = 9'(bpd_pkg::CODE_COUNT);
                  ent_in   = 8'd0;
                  phase_in = PH_LEN_HI;
               end else begin
                  pos_in   = pos_sum[8:0];
                  phase_in = PH_LEFT;
               end
            end
            PH_LEFT, PH_RIGHT: begin
               if (phase_ff == PH_LEFT) begin
                  tbl_wr.left_we = 1'b1;
               end else begin
                  tbl_wr.right_we = 1'b1;
               end
               if (phase_ff == PH_LEFT && data_byte != pos_ff[7:0]) begin
                  phase_in = PH_RIGHT;
               end else begin
                  pos_in = fin_pos;
                  ent_in = ent_dec;
                  if (fin_pos >= 9'(bpd_pkg::CODE_COUNT)) begin
                     phase_in = PH_LEN_HI;
                  end else if (ent_dec == 8'd0) begin
                     phase_in = PH_COUNT;
                  end else begin
                     phase_in = PH_LEFT;
                  end
               end
            end
            PH_LEN_HI: begin
               len_hi_in = data_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               rem_in = new_len;
               if (new_len == 16'd0) begin
                  pos_in       = 9'd0;
                  ent_in       = 8'd0;
                  phase_in     = PH_COUNT;
                  tbl_wr.clear = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               start  = 1'b1;
               rem_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  pos_in       = 9'd0;
                  ent_in       = 8'd0;
                  phase_in     = PH_COUNT;
                  tbl_wr.clear = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HEADER;
               hdr_in   = 2'd0;
            end
         endcase
         if (stream_end) begin
            phase_in = PH_HEADER;
            hdr_in   = 2'd0;
            pos_in   = 9'd0;
            ent_in   = 8'd0;
            rem_in   = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hdr_ff    <= 2'd0;
         pos_ff    <= 9'd0;
         ent_ff    <= 8'd0;
         rem_ff    <= 16'd0;
         len_hi_ff <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         hdr_ff    <= hdr_in;
         pos_ff    <= pos_in;
         ent_ff    <= ent_in;
         rem_ff    <= rem_in;
         len_hi_ff <= len_hi_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/bpd_expander.sv
// Stack-driven expansion of one code into plain bytes, with pair tables and result register.
`default_nettype none
module bpd_expander #(
   parameter int STACK_DEPTH   = 256,
   parameter int MAX_EXPANSION = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  bpd_pkg::tbl_wr_type      tbl_wr,
   input  wire logic                start,
   input  wire logic [7:0]          code,
   output logic                     idle,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run,
   output logic [1:0]               rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int LW = $clog2(STACK_DEPTH + 1);
   localparam int NW = $clog2(MAX_EXPANSION + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_POP   = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [7:0]    cur_ff, cur_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [7:0]    held_ff, held_in;
   logic          held_valid_ff, held_valid_in;
   logic [1:0]    stat_ff, stat_in;
   logic [255:0]  lvalid_ff, lvalid_in;
   logic          clear_pend_ff, clear_pend_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;
   logic [1:0]    out_stat_ff, out_stat_in;

   logic [7:0]    left_rdata;
   logic [7:0]    right_rdata;
   logic [7:0]    stack_rdata;
   logic [7:0]    left_val;
   logic          out_free;
   logic [NW-1:0] cnt_inc;
   logic          overflow;
   logic          stack_we;
   logic          stack_re;
   logic          tbl_re;

   assign out_free = !out_valid_ff || rsp_ready;
   assign left_val = lvalid_ff[cur_ff] ? left_rdata : cur_ff;
   assign cnt_inc  = cnt_ff + NW'(1);
   assign overflow = ({1'b0, lvl_ff} + (LW+1)'(2)) > (LW+1)'(STACK_DEPTH);
   assign tbl_re   = state_ff == ST_LOOK;
   assign stack_re = state_ff == ST_POP;
   assign stack_we = state_ff == ST_EVAL && left_val != cur_ff && !overflow;

   bpd_ram #(.WIDTH(8), .DEPTH(bpd_pkg::CODE_COUNT)) u_left_ram (
      .clock   (clock),
      .wr_en   (tbl_wr.left_we),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.data),
      .rd_en   (tbl_re),
      .rd_addr (cur_ff),
      .rd_data (left_rdata)
   );

   bpd_ram #(.WIDTH(8), .DEPTH(bpd_pkg::CODE_COUNT)) u_right_ram (
      .clock   (clock),
      .wr_en   (tbl_wr.right_we),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.data),
      .rd_en   (tbl_re),
      .rd_addr (cur_ff),
      .rd_data (right_rdata)
   );

   bpd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (lvl_ff[AW-1:0]),
      .wr_data (right_rdata),
      .rd_en   (stack_re),
      .rd_addr (lvl_in[AW-1:0]),
      .rd_data (stack_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      lvl_in        = lvl_ff;
      cnt_in        = cnt_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      stat_in       = stat_ff;
      lvalid_in     = lvalid_ff;
      clear_pend_in = clear_pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_stat_in   = out_stat_ff;

      if (tbl_wr.left_we) begin
         lvalid_in[tbl_wr.addr] = 1'b1;
      end
      if (tbl_wr.clear) begin
         if (start) begin
            clear_pend_in = 1'b1;
         end else begin
            lvalid_in = '0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cur_in        = code;
               lvl_in        = '0;
               cnt_in        = '0;
               held_valid_in = 1'b0;
               stat_in       = bpd_pkg::STATUS_OK;
               state_in      = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (left_val == cur_ff) begin
               if (!held_valid_ff || out_free) begin
                  if (held_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_byte_in  = held_ff;
                     out_last_in  = 1'b0;
                     out_stat_in  = bpd_pkg::STATUS_OK;
                  end
                  held_in       = cur_ff;
                  held_valid_in = 1'b1;
                  cnt_in        = cnt_inc;
                  if (lvl_ff == '0) begin
                     state_in = ST_FLUSH;
                  end else if (cnt_inc >= NW'(MAX_EXPANSION)) begin
                     stat_in  = bpd_pkg::STATUS_TRUNC;
                     state_in = ST_FLUSH;
                  end else begin
                     state_in = ST_POP;
                  end
               end
            end else if (overflow) begin
               stat_in  = bpd_pkg::STATUS_OVERFLOW;
               state_in = ST_FLUSH;
            end else begin
               lvl_in   = lvl_ff + LW'(1);
               cur_in   = left_val;
               state_in = ST_LOOK;
            end
         end
         ST_POP: begin
            lvl_in   = lvl_ff - LW'(1);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cur_in   = stack_rdata;
            state_in = ST_LOOK;
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = held_valid_ff ? held_ff : 8'd0;
               out_last_in  = 1'b1;
               out_stat_in  = stat_ff;
               state_in     = ST_IDLE;
               if (clear_pend_ff) begin
                  lvalid_in     = '0;
                  clear_pend_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lvalid_ff     <= '0;
         clear_pend_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lvalid_ff     <= lvalid_in;
         clear_pend_ff <= clear_pend_in;
         out_valid_ff  <= out_valid_in;
         held_valid_ff <= held_valid_in;
      end
      cur_ff      <= cur_in;
      lvl_ff      <= lvl_in;
      cnt_ff      <= cnt_in;
      held_ff     <= held_in;
      stat_ff     <= stat_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_stat_ff <= out_stat_in;
   end

   assign idle            = state_ff == ST_IDLE;
   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_status      = out_stat_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/byte_pair_decompressor_core.sv
// Top level of the byte-pair decompressor core.
// Header, pair-table and length bytes give no result and are taken one per cycle while the
// expander is idle. A data byte is expanded by one shared stack sequencer: each pair node
// costs a table read and a compare, each plain byte a table read, compare, stack pop and
// stack read; the input stays busy until the byte is expanded, longer if the result side
// stalls. Stack and tables are registered-read RAMs, so each read has a state of its own.
// A finished result waits in an output register while the next byte is taken.
`default_nettype none
module byte_pair_decompressor_core #(
   parameter int STACK_DEPTH   = 256,
   parameter int MAX_EXPANSION = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_stream_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_run,
   output logic [1:0]      rsp_status
);

   bpd_pkg::tbl_wr_type tbl_wr;
   logic                start;
   logic                idle;
   logic                accept;

   assign req_ready = idle && !reset;
   assign accept    = req_valid && req_ready;

   bpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .stream_end (req_stream_end),
      .tbl_wr     (tbl_wr),
      .start      (start)
   );

   bpd_expander #(
      .STACK_DEPTH   (STACK_DEPTH),
      .MAX_EXPANSION (MAX_EXPANSION)
   ) u_expander (
      .clock           (clock),
      .reset           (reset),
      .tbl_wr          (tbl_wr),
      .start           (start),
      .code            (req_data_byte),
      .idle            (idle),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire
